// ===== hdl/cpws_pkg.sv =====
// shared sizes, codes, beat types and index helper for the wall segment block
package cpws_pkg;

   // table and coordinate sizes
   localparam int TABLE_DEPTH = 1024;
   localparam int COORD_BITS  = 16;
   localparam int INDEX_BITS  = 10;
   localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // datapath widths derived from the coordinate width
   localparam int DIFF_BITS = COORD_BITS + 1;        // coordinate difference
   localparam int T_BITS    = 2 * DIFF_BITS;         // signed projection dot product
   localparam int LEN_BITS  = 2 * DIFF_BITS - 1;     // unsigned squared length
   localparam int PROD_BITS = DIFF_BITS + T_BITS;    // serial multiplier result
   localparam int QUO_BITS  = COORD_BITS;            // interior offset magnitude

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // clamp codes
   localparam logic [1:0] CLAMP_INTERIOR = 2'd0;
   localparam logic [1:0] CLAMP_START    = 2'd1;
   localparam logic [1:0] CLAMP_END      = 2'd2;

   typedef struct packed {
      logic                         op;
      logic [INDEX_BITS-1:0]        wall_index;
      logic signed [COORD_BITS-1:0] vertex_x_in;
      logic signed [COORD_BITS-1:0] vertex_y_in;
      logic [INDEX_BITS-1:0]        next_in;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] closest_x;
      logic signed [COORD_BITS-1:0] closest_y;
      logic [1:0]                   clamp_kind;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [ADDR_BITS-1:0]         next;
   } vertex_type;

   // wrap an index field onto the table, a plain mask for power-of-two depths
   function automatic logic [ADDR_BITS-1:0] wrap_index(input logic [INDEX_BITS-1:0] v);
      return ADDR_BITS'(v % TABLE_DEPTH);
   endfunction

endpackage

// ===== hdl/closest_point_on_wall_segment.sv =====
// top level: vertex table, query sequencer and serial arithmetic units
//
// Command-style block. A beat on req_data is taken at a rising edge where start is
// high and busy is low. op selects a table write or a closest-point query.
// A write stores x, y and the next-vertex index; busy stays low, so
// writes may follow each other every cycle. A query reads the start vertex and
// then its next vertex from the table, forms the projection with four bit-serial
// multipliers working side by side, and for an interior point scales both deltas
// by the projection and divides by the squared length with two radix-2 dividers.
// The answer appears on rsp_data for one cycle with rsp_valid high; there is no
// way to hold it off, so capture it in that cycle.
// A query's result is paced by the serial multiply passes (one bit a cycle)
// and the two dividers (one quotient bit a cycle); a result clamped to an end
// skips the scaling and division. busy drops in the result cycle, so the next
// query can be accepted in that cycle.
// Reset returns the sequencer to idle; table contents are undefined until
// written and are not cleared.
module closest_point_on_wall_segment (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cpws_pkg::req_type req_data,
   output logic              rsp_valid,
   output cpws_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_DIFF,
      S_PRODUCT,
      S_CLASSIFY,
      S_SCALE,
      S_DIVIDE
   } state_type;

   localparam int C = cpws_pkg::COORD_BITS;
   localparam int D = cpws_pkg::DIFF_BITS;
   localparam int T = cpws_pkg::T_BITS;
   localparam int L = cpws_pkg::LEN_BITS;
   localparam int P = cpws_pkg::PROD_BITS;

   state_type state_ff, state_in;

   logic signed [C-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [C-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [C-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [D-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [D-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic signed [T-1:0] t_ff, t_in;
   logic [L-1:0]        len_ff, len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cpws_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                             accept;
   logic                             ram_wr_en;
   logic [cpws_pkg::ADDR_BITS-1:0]   ram_wr_addr;
   cpws_pkg::vertex_type             ram_wr_data;
   logic                             ram_rd_en;
   logic [cpws_pkg::ADDR_BITS-1:0]   ram_rd_addr;
   logic [$bits(cpws_pkg::vertex_type)-1:0] ram_rd_bits;
   cpws_pkg::vertex_type             rd_vertex;

   logic                mul_start_all;
   logic                mul_start_scale;
   logic signed [D-1:0] mul_a [4];
   logic signed [T-1:0] mul_b [4];
   logic [3:0]          mul_done;
   logic signed [P-1:0] mul_prod [4];
   logic signed [D-1:0] dx_mag, dy_mag;

   logic                div_start;
   logic [1:0]          div_done;
   logic [C-1:0]        div_quo [2];
   logic [C-1:0]        off_x, off_y;
   logic                t_le_zero, t_ge_len;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // table write on an accepted write beat
   assign ram_wr_en   = accept && (req_data.op == cpws_pkg::OP_WRITE);
   assign ram_wr_addr = cpws_pkg::wrap_index(req_data.wall_index);
   always_comb begin
      ram_wr_data.x    = req_data.vertex_x_in;
      ram_wr_data.y    = req_data.vertex_y_in;
      ram_wr_data.next = cpws_pkg::wrap_index(req_data.next_in);
   end

   // table read: start vertex on query accept, then its successor
   assign ram_rd_en   = (accept && (req_data.op == cpws_pkg::OP_QUERY)) ||
                        (state_ff == S_READ_A);
   assign ram_rd_addr = (state_ff == S_READ_A) ? rd_vertex.next
                                              : cpws_pkg::wrap_index(req_data.wall_index);
   assign rd_vertex   = ram_rd_bits;

   cpws_ram #(
      .WIDTH ($bits(cpws_pkg::vertex_type)),
      .DEPTH (cpws_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   // multiplier operands: projection and squared length, then scaled deltas
   assign dx_mag = dx_ff[D-1] ? -dx_ff : dx_ff;
   assign dy_mag = dy_ff[D-1] ? -dy_ff : dy_ff;
   always_comb begin
      if (state_ff == S_CLASSIFY) begin
         mul_a[0] = dx_mag;
         mul_b[0] = t_ff;
         mul_a[1] = dy_mag;
         mul_b[1] = t_ff;
      end else begin
         mul_a[0] = dx_ff;
         mul_b[0] = T'(ex_ff);
         mul_a[1] = dy_ff;
         mul_b[1] = T'(ey_ff);
      end
      mul_a[2] = dx_ff;
      mul_b[2] = T'(dx_ff);
      mul_a[3] = dy_ff;
      mul_b[3] = T'(dy_ff);
   end

   // end-point tests on the projection
   assign t_le_zero = t_ff[T-1] || (t_ff == '0);
   assign t_ge_len  = (t_ff >= $signed({1'b0, len_ff}));

   assign mul_start_all   = (state_ff == S_DIFF);
   assign mul_start_scale = (state_ff == S_CLASSIFY) && !t_le_zero && !t_ge_len;
   assign div_start       = (state_ff == S_SCALE) && mul_done[0];

   for (genvar i = 0; i < 4; i++) begin : g_mul
      cpws_mul u_mul (
         .clock   (clock),
         .reset   (reset),
         .start   (mul_start_all || ((i < 2) && mul_start_scale)),
         .mult_a  (mul_a[i]),
         .mult_b  (mul_b[i]),
         .done    (mul_done[i]),
         .product (mul_prod[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_div
      cpws_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .numer    (mul_prod[i]),
         .denom    (len_ff),
         .done     (div_done[i]),
         .quotient (div_quo[i])
      );
   end

   // signed offsets along each axis, wrapped to coordinate width
   assign off_x = dx_ff[D-1] ? (C'(0) - div_quo[0]) : div_quo[0];
   assign off_y = dy_ff[D-1] ? (C'(0) - div_quo[1]) : div_quo[1];

   // query sequencer
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      t_in         = t_ff;
      len_in       = len_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.op == cpws_pkg::OP_QUERY)) begin
               px_in    = req_data.point_x;
               py_in    = req_data.point_y;
               state_in = S_READ_A;
            end
         end
         S_READ_A: begin
            ax_in    = rd_vertex.x;
            ay_in    = rd_vertex.y;
            state_in = S_READ_B;
         end
         S_READ_B: begin
            bx_in    = rd_vertex.x;
            by_in    = rd_vertex.y;
            dx_in    = D'($signed(rd_vertex.x)) - D'(ax_ff);
            dy_in    = D'($signed(rd_vertex.y)) - D'(ay_ff);
            ex_in    = D'(px_ff) - D'(ax_ff);
            ey_in    = D'(py_ff) - D'(ay_ff);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            state_in = S_PRODUCT;
         end
         S_PRODUCT: begin
            if (mul_done[0]) begin
               t_in     = T'(mul_prod[0]) + T'(mul_prod[1]);
               len_in   = L'(mul_prod[2] + mul_prod[3]);
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            if (t_le_zero) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.closest_x  = ax_ff;
               rsp_data_in.closest_y  = ay_ff;
               rsp_data_in.clamp_kind = cpws_pkg::CLAMP_START;
               state_in               = S_IDLE;
            end else if (t_ge_len) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.closest_x  = bx_ff;
               rsp_data_in.closest_y  = by_ff;
               rsp_data_in.clamp_kind = cpws_pkg::CLAMP_END;
               state_in               = S_IDLE;
            end else begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (mul_done[0]) begin
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done[0]) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.closest_x  = $signed(C'(ax_ff) + off_x);
               rsp_data_in.closest_y  = $signed(C'(ay_ff) + off_y);
               rsp_data_in.clamp_kind = cpws_pkg::CLAMP_INTERIOR;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      t_ff        <= t_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/cpws_ram.sv =====
// generic simple dual-port ram with registered read
module cpws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cpws_mul.sv =====
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
module cpws_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [cpws_pkg::DIFF_BITS-1:0]  mult_a,
   input  logic signed [cpws_pkg::T_BITS-1:0]     mult_b,
   output logic                                   done,
   output logic signed [cpws_pkg::PROD_BITS-1:0]  product
);

   localparam int CNT_BITS = $clog2(cpws_pkg::DIFF_BITS);

   logic [cpws_pkg::DIFF_BITS-1:0]        a_ff, a_in;
   logic signed [cpws_pkg::PROD_BITS-1:0] b_ff, b_in;
   logic signed [cpws_pkg::PROD_BITS-1:0] acc_ff, acc_in;
   logic signed [cpws_pkg::PROD_BITS-1:0] addend;
   logic [CNT_BITS-1:0]                   cnt_ff, cnt_in;
   logic                                  run_ff, run_in;
   logic                                  done_ff, done_in;
   logic                                  last;

   // one partial product per cycle, the sign bit of a carries negative weight
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      last    = (cnt_ff == CNT_BITS'(cpws_pkg::DIFF_BITS - 1));
      addend  = a_ff[0] ? b_ff : '0;
      if (start) begin
         a_in   = mult_a;
         b_in   = cpws_pkg::PROD_BITS'(mult_b);
         acc_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = last ? (acc_ff - addend) : (acc_ff + addend);
         a_in   = a_ff >> 1;
         b_in   = b_ff <<< 1;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hdl/cpws_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// expects numer < denom * 2**QUO_BITS so the quotient fits QUO_BITS
module cpws_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cpws_pkg::PROD_BITS-1:0]      numer,
   input  logic [cpws_pkg::LEN_BITS-1:0]       denom,
   output logic                                done,
   output logic [cpws_pkg::QUO_BITS-1:0]       quotient
);

   localparam int CNT_BITS = $clog2(cpws_pkg::QUO_BITS);

   logic [cpws_pkg::LEN_BITS-1:0] rem_ff, rem_in;
   logic [cpws_pkg::LEN_BITS-1:0] den_ff, den_in;
   logic [cpws_pkg::QUO_BITS-1:0] low_ff, low_in;
   logic [cpws_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [cpws_pkg::LEN_BITS:0]   trial;
   logic                          fits;
   logic                          last;

   // shift in the next numerator bit, subtract when the divisor fits
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, low_ff[cpws_pkg::QUO_BITS-1]};
      fits    = (trial >= {1'b0, den_ff});
      last    = (cnt_ff == CNT_BITS'(cpws_pkg::QUO_BITS - 1));
      if (start) begin
         rem_in = numer[cpws_pkg::QUO_BITS +: cpws_pkg::LEN_BITS];
         low_in = numer[cpws_pkg::QUO_BITS-1:0];
         den_in = denom;
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? cpws_pkg::LEN_BITS'(trial - {1'b0, den_ff})
                       : trial[cpws_pkg::LEN_BITS-1:0];
         low_in = low_ff << 1;
         quo_in = {quo_ff[cpws_pkg::QUO_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/cpws_checker.sv =====
// port-level checks for the wall segment block and their bind
module cpws_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input cpws_pkg::req_type req_data,
   input logic              rsp_valid,
   input cpws_pkg::rsp_type rsp_data
);

   // reset leaves the block idle with no result pending
   assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // an accepted query occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op == cpws_pkg::OP_QUERY)) |=> busy)
      else $error("query accepted without going busy");

   // a write completes in its accept cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op == cpws_pkg::OP_WRITE)) |=> (!busy && !rsp_valid))
      else $error("write produced busy or a result");

   // a result frees the block and never repeats in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy ##1 !rsp_valid))
      else $error("result strobe without release or repeated");

   // clamp code is always a defined kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.clamp_kind == cpws_pkg::CLAMP_INTERIOR) ||
                     (rsp_data.clamp_kind == cpws_pkg::CLAMP_START) ||
                     (rsp_data.clamp_kind == cpws_pkg::CLAMP_END)))
      else $error("undefined clamp kind on result");

endmodule

bind closest_point_on_wall_segment cpws_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
